@@ hdl/lsvc_pkg.sv @@
// Shared types, constants and helpers of the linear sum violation cost block.
`default_nettype none
package lsvc_pkg;

  // store geometry
  localparam int MaxValues = 128;
  localparam int AddrW     = $clog2(MaxValues);
  localparam int CntW      = $clog2(MaxValues + 1);

  // field widths
  localparam int ValW  = 10;
  localparam int SumW  = 17;
  localparam int HamW  = 8;
  localparam int StatW = 2;
  localparam int CfgW  = 17;
  localparam int IdxW  = 2;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegMode      = 2'd0;
  localparam logic [IdxW-1:0] RegTarget    = 2'd1;
  localparam logic [IdxW-1:0] RegDomainMax = 2'd2;

  // reset values of the configuration registers
  localparam logic [1:0]      ModeRst      = 2'd0;
  localparam logic [SumW-1:0] TargetRst    = 17'd1;
  localparam logic [ValW-1:0] DomainMaxRst = 10'd100;

  // constraint kinds; the unused code behaves as equal
  typedef enum logic [1:0] {
    MODE_EQ = 2'd0,
    MODE_LE = 2'd1,
    MODE_GE = 2'd2
  } mode_e;

  // result status codes
  localparam logic [StatW-1:0] StatusOk      = 2'd0;
  localparam logic [StatW-1:0] StatusUnreach = 2'd1;
  localparam logic [StatW-1:0] StatusDropped = 2'd2;

  // repair step kinds
  typedef enum logic [1:0] {
    OP_RAISE  = 2'd0,  // raise first min by the gap, capped at max
    OP_LOWER  = 2'd1,  // lower first max by the gap, floored at 1
    OP_TO_ONE = 2'd2,  // set first max to 1
    OP_TO_MAX = 2'd3   // set first min to max
  } op_e;

  localparam logic [ValW-1:0] ValOne = 10'd1;

  // a zero domain max acts as 1
  function automatic logic [ValW-1:0] eff_max(logic [ValW-1:0] dm);
    eff_max = (dm == '0) ? ValOne : dm;
  endfunction

  // clamp a value into 1..dm
  function automatic logic [ValW-1:0] clamp_val(logic [ValW-1:0] v, logic [ValW-1:0] dm);
    if (v == '0) begin
      clamp_val = ValOne;
    end else if (v > dm) begin
      clamp_val = dm;
    end else begin
      clamp_val = v;
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/linear_sum_violation_cost.sv @@
// Top level: loads values, then computes Hamming and Manhattan costs of a sum constraint.
//
// Usage:
//   Values arrive on value_i/last_i and a beat is taken at a clock edge with
//   start high and busy low. Each value is clamped into 1..domain_max and
//   stored; up to 128 values fit, later ones are dropped and flagged.
//   A beat with last_i high ends the set and starts the cost phase; busy
//   stays high until the result goes out.
//   Result: done_o is high for exactly one cycle together with hamming_cost_o,
//   manhattan_cost_o and status_o. The receiver cannot stall the result.
//   Sequence: loading accepts one value per cycle while busy is low. After
//   the last value, the cost phase makes one read pass over the value RAM
//   to clamp and sum, then per repair one full min/max scan of the RAM
//   through its read port, one check and one write-back. The shared compare
//   unit and the single RAM read port serve every scan.
//   Configuration (cfg_we_i/cfg_idx_i/cfg_data_i) is to be written only while
//   idle; the block itself does not enforce this.
//   Reset clears counters, flags and the sequencer, and sets mode 0, target 1,
//   domain max 100. The value RAM is not cleared; only written entries are read.
`default_nettype none
module linear_sum_violation_cost (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config write port
  input  wire logic                        cfg_we_i,
  input  wire logic [lsvc_pkg::IdxW-1:0]   cfg_idx_i,
  input  wire logic [lsvc_pkg::CfgW-1:0]   cfg_data_i,
  // input beats
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lsvc_pkg::ValW-1:0]   value_i,
  input  wire logic                        last_i,
  // results
  output logic                             done_o,
  output logic      [lsvc_pkg::HamW-1:0]   hamming_cost_o,
  output logic      [lsvc_pkg::SumW-1:0]   manhattan_cost_o,
  output logic      [lsvc_pkg::StatW-1:0]  status_o
);

  import lsvc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SUM    = 7'b0000010,
    ST_EVAL   = 7'b0000100,
    ST_CHECK  = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [1:0]      mode_q;
  logic [SumW-1:0] target_q;
  logic [ValW-1:0] dmax_q;

  // load and sequencer registers
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SumW-1:0]  hi_q, hi_d;
  logic [SumW-1:0]  manh_q, manh_d;
  logic             unreach_q, unreach_d;
  logic [HamW-1:0]  repair_q, repair_d;
  op_e              op_q, op_d;
  logic [ValW-1:0]  best_val_q, best_val_d;
  logic [AddrW-1:0] best_idx_q, best_idx_d;

  // result registers
  logic             done_q, done_d;
  logic [HamW-1:0]  ham_out_q, ham_out_d;
  logic [SumW-1:0]  manh_out_q, manh_out_d;
  logic [StatW-1:0] stat_out_q, stat_out_d;

  // RAM port signals
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ValW-1:0]  ram_wdata;
  logic             ram_re;
  logic [ValW-1:0]  ram_rdata;

  // helpers
  logic [ValW-1:0]  dm;
  logic             accept;
  logic             issue;
  logic [CntW-1:0]  cnt_m1;
  logic             last_rd;
  logic [ValW-1:0]  rd_clamped;
  logic             find_max;
  logic             better;
  logic [SumW-1:0]  gap_up;
  logic [SumW-1:0]  gap_dn;
  logic [ValW-1:0]  room;
  logic [ValW-1:0]  new_val;
  logic [SumW:0]    sum_upd;
  logic [SumW-1:0]  n_ext;
  logic             sum_ok;

  // room left in the store
  function automatic logic issue_load(logic [CntW-1:0] cnt);
    issue_load = (cnt < CntW'(MaxValues));
  endfunction

  assign dm         = eff_max(dmax_q);
  assign accept     = start && !busy;
  assign issue      = (idx_q < cnt_q);
  assign cnt_m1     = cnt_q - CntW'(1);
  assign last_rd    = rd_vld_q && ({1'b0, rd_idx_q} == cnt_m1);
  assign rd_clamped = clamp_val(ram_rdata, dm);
  assign n_ext      = SumW'(cnt_q);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeRst;
      target_q <= TargetRst;
      dmax_q   <= DomainMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:      mode_q   <= cfg_data_i[1:0];
        RegTarget:    target_q <= cfg_data_i[SumW-1:0];
        RegDomainMax: dmax_q   <= cfg_data_i[ValW-1:0];
        default:      ;
      endcase
    end
  end

  // constraint satisfied at the current sum
  always_comb begin
    case (mode_q)
      MODE_LE: sum_ok = (sum_q <= target_q);
      MODE_GE: sum_ok = (sum_q >= target_q);
      default: sum_ok = (sum_q == target_q);
    endcase
  end

  // shared compare for the min/max scan: strict, so the first one wins
  assign find_max = (op_q == OP_LOWER) || (op_q == OP_TO_ONE);
  assign better   = (rd_idx_q == '0) ||
                    (find_max ? (ram_rdata > best_val_q) : (ram_rdata < best_val_q));

  // repair value for the chosen entry
  assign gap_up = target_q - sum_q;
  assign gap_dn = sum_q - target_q;
  assign room   = dm - best_val_q;
  always_comb begin
    case (op_q)
      OP_RAISE:  new_val = (gap_up <= SumW'(room)) ? (best_val_q + gap_up[ValW-1:0]) : dm;
      OP_LOWER:  new_val = (gap_dn < SumW'(best_val_q)) ?
                           (best_val_q - gap_dn[ValW-1:0]) : ValOne;
      OP_TO_ONE: new_val = ValOne;
      OP_TO_MAX: new_val = dm;
      default:   new_val = best_val_q;
    endcase
  end
  assign sum_upd = {1'b0, sum_q} + (SumW+1)'(new_val) - (SumW+1)'(best_val_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    sum_d      = sum_q;
    hi_d       = hi_q;
    manh_d     = manh_q;
    unreach_d  = unreach_q;
    repair_d   = repair_q;
    op_d       = op_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    done_d     = 1'b0;
    ham_out_d  = ham_out_q;
    manh_out_d = manh_out_q;
    stat_out_d = stat_out_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[AddrW-1:0];
    ram_wdata  = clamp_val(value_i, dm);
    ram_re     = 1'b0;

    case (state_q)
      // load one value per beat
      ST_IDLE: begin
        if (accept) begin
          if (issue_load(cnt_q)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            idx_d    = '0;
            sum_d    = '0;
            hi_d     = '0;
            repair_d = '0;
            state_d  = ST_SUM;
          end
        end
      end

      // re-clamp pass: write back, sum values and the domain bound
      ST_SUM: begin
        if (issue) begin
          ram_re   = 1'b1;
          idx_d    = idx_q + CntW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[AddrW-1:0];
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q;
          ram_wdata = rd_clamped;
          sum_d     = sum_q + SumW'(rd_clamped);
          hi_d      = hi_q + SumW'(dm);
        end
        if (last_rd) begin
          state_d = ST_EVAL;
        end
      end

      // Manhattan cost and reachability
      ST_EVAL: begin
        repair_d = '0;
        case (mode_q)
          MODE_LE: begin
            manh_d    = (sum_q > target_q) ? (sum_q - target_q) : '0;
            unreach_d = (target_q < n_ext);
          end
          MODE_GE: begin
            manh_d    = (target_q > sum_q) ? (target_q - sum_q) : '0;
            unreach_d = (target_q > hi_q);
          end
          default: begin
            manh_d    = (sum_q > target_q) ? (sum_q - target_q) : (target_q - sum_q);
            unreach_d = (target_q < n_ext) || (target_q > hi_q);
          end
        endcase
        state_d = unreach_d ? ST_DONE : ST_CHECK;
      end

      // loop head: stop when satisfied or the step guard runs out
      ST_CHECK: begin
        if (sum_ok || (CntW'(repair_q) > cnt_q)) begin
          state_d = ST_DONE;
        end else begin
          case (mode_q)
            MODE_LE: op_d = OP_TO_ONE;
            MODE_GE: op_d = OP_TO_MAX;
            default: op_d = (sum_q < target_q) ? OP_RAISE : OP_LOWER;
          endcase
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end

      // scan the store for the first min or max
      ST_SCAN: begin
        if (issue) begin
          ram_re   = 1'b1;
          idx_d    = idx_q + CntW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[AddrW-1:0];
        end
        if (rd_vld_q && better) begin
          best_val_d = ram_rdata;
          best_idx_d = rd_idx_q;
        end
        if (last_rd) begin
          state_d = ST_UPDATE;
        end
      end

      // apply one repair
      ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = new_val;
        sum_d     = sum_upd[SumW-1:0];
        repair_d  = repair_q + HamW'(1);
        state_d   = ST_CHECK;
      end

      // emit result beat and clear the set
      ST_DONE: begin
        done_d     = 1'b1;
        ham_out_d  = unreach_q ? '0 : repair_q;
        manh_out_d = manh_q;
        stat_out_d = ovf_q ? StatusDropped : (unreach_q ? StatusUnreach : StatusOk);
        cnt_d      = '0;
        ovf_d      = 1'b0;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      repair_q  <= '0;
      unreach_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      repair_q  <= repair_d;
      unreach_q <= unreach_d;
      done_q    <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    sum_q      <= sum_d;
    hi_q       <= hi_d;
    manh_q     <= manh_d;
    op_q       <= op_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    ham_out_q  <= ham_out_d;
    manh_out_q <= manh_out_d;
    stat_out_q <= stat_out_d;
  end

  // value store, reused as the working copy
  lsvc_ram #(
    .Width (ValW),
    .Depth (MaxValues)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign hamming_cost_o   = ham_out_q;
  assign manhattan_cost_o = manh_out_q;
  assign status_o         = stat_out_q;

`ifndef ASSERT_OFF
  // a set ending beat always starts the cost phase
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("last beat did not start cost phase");

  // the store fill never passes its depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxValues))
    else $error("value count beyond store depth");

  // repairs are bounded by the step guard
  a_repair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW'(repair_q) <= cnt_q + CntW'(1)) || (state_q == ST_IDLE))
    else $error("repair count beyond guard");

  // an unreachable result reports no repairs
  a_unreach_ham: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StatusUnreach)) |-> (hamming_cost_o == '0))
    else $error("unreachable result with repairs");

  // a result beat is only shown once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");
`endif

endmodule
`default_nettype wire

@@ hdl/lsvc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module lsvc_ram #(
  parameter int Width = 10,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
